[rtl/assert_macros.svh]
// Assertion helpers, sampled on clk_i and off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge.
`define BQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define BQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/bqsf_pkg.sv]
package bqsf_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned FRAC_QW     = 32;
  localparam int unsigned GRAD_QW     = 31;

  localparam logic [16:0] W_ONE     = 17'd65536;
  localparam logic [16:0] FLOOR_RST = 17'd1;
  localparam logic [31:0] FRAC_HALF = 32'd32768;
  localparam logic [31:0] FRAC_SAT  = 32'hFFFF_FFFF;
  localparam logic [31:0] GRAD_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] GRAD_MIN  = 32'h8000_0000;

  // Differences formed at the front, 33-bit two's complement.
  typedef struct packed {
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] nsx;
    logic [32:0] ntx;
    logic [32:0] nsy;
    logic [32:0] nty;
  } diff_t;

  typedef struct packed {
    logic        zero;
    logic        sat;
    logic        neg;
    logic [32:0] ext;
  } fdtag_t;

  typedef struct packed {
    logic        sat;
    logic        neg;
    logic [16:0] wt;
  } gdtag_t;

  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
  } frac_t;

  // Magnitude of a 33-bit difference of two 32-bit values; always fits 32 bits.
  function automatic logic [31:0] mag33(logic [32:0] v);
    logic [32:0] a;
    a = v[32] ? (33'd0 - v) : v;
    return a[31:0];
  endfunction

endpackage

[rtl/bqsf_front.sv]
module bqsf_front (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          cell_x_low_i,
  input  logic [31:0]          cell_x_high_i,
  input  logic [31:0]          cell_y_low_i,
  input  logic [31:0]          cell_y_high_i,
  input  logic [31:0]          point_x_i,
  input  logic [31:0]          point_y_i,
  input  logic                 full_i,
  output logic                 push_o,
  output bqsf_pkg::diff_t      item_o
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o.dx  = {cell_x_high_i[31], cell_x_high_i} - {cell_x_low_i[31], cell_x_low_i};
    item_o.dy  = {cell_y_high_i[31], cell_y_high_i} - {cell_y_low_i[31], cell_y_low_i};
    item_o.nsx = {point_x_i[31], point_x_i} - {cell_x_low_i[31], cell_x_low_i};
    item_o.ntx = {cell_x_high_i[31], cell_x_high_i} - {point_x_i[31], point_x_i};
    item_o.nsy = {point_y_i[31], point_y_i} - {cell_y_low_i[31], cell_y_low_i};
    item_o.nty = {cell_y_high_i[31], cell_y_high_i} - {point_y_i[31], point_y_i};
  end

endmodule

[rtl/bqsf_queue.sv]
`include "assert_macros.svh"

module bqsf_queue #(
  parameter int unsigned DEPTH = bqsf_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bqsf_pkg::diff_t  item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output bqsf_pkg::diff_t  item_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bqsf_pkg::diff_t mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `BQ_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH))
  `BQ_ASSERT(a_no_pop_empty, !pop_i || valid_o)

endmodule

[rtl/bqsf_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Caller guarantees rem_i < den_i, so the quotient fits QW bits.
module bqsf_div #(
  parameter int unsigned QW = bqsf_pkg::FRAC_QW,
  parameter int unsigned DW = 32,
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] lo_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] lq_q  [QW];
  logic [DW-1:0] den_q [QW];
  logic [TW-1:0] tag_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [DW-1:0] rin, din;
    logic [QW-1:0] lin;
    logic [TW-1:0] tin;
    logic [DW:0]   r2, diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign rin = rem_i;
      assign lin = lo_i;
      assign din = den_i;
      assign tin = tag_i;
    end else begin : g_next
      assign rin = rem_q[s-1];
      assign lin = lq_q[s-1];
      assign din = den_q[s-1];
      assign tin = tag_q[s-1];
    end

    assign r2   = {rin, lin[QW-1]};
    assign diff = r2 - {1'b0, din};
    assign ge   = (r2 >= {1'b0, din});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? diff[DW-1:0] : r2[DW-1:0];
        lq_q[s]  <= {lin[QW-2:0], ge};
        den_q[s] <= din;
        tag_q[s] <= tin;
      end
    end
  end

  assign quo_o = lq_q[QW-1];
  assign tag_o = tag_q[QW-1];

endmodule

[rtl/bqsf_back.sv]
`include "assert_macros.svh"

module bqsf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [16:0]      shape_floor_i,
  input  logic             in_valid_i,
  input  bqsf_pkg::diff_t  item_i,
  output logic             pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [16:0]      weight_1_o,
  output logic [16:0]      weight_2_o,
  output logic [16:0]      weight_3_o,
  output logic [16:0]      weight_4_o,
  output logic [31:0]      grad_1_x_o,
  output logic [31:0]      grad_1_y_o,
  output logic [31:0]      grad_2_x_o,
  output logic [31:0]      grad_2_y_o,
  output logic [31:0]      grad_3_x_o,
  output logic [31:0]      grad_3_y_o,
  output logic [31:0]      grad_4_x_o,
  output logic [31:0]      grad_4_y_o
);

  localparam int unsigned FQW = bqsf_pkg::FRAC_QW;
  localparam int unsigned GQW = bqsf_pkg::GRAD_QW;
  localparam int unsigned LAT = FQW + GQW + 2;
  localparam int unsigned FTW = $bits(bqsf_pkg::fdtag_t);
  localparam int unsigned GTW = $bits(bqsf_pkg::gdtag_t);

  // grad lanes 1x,1y,2x,2y,3x,3y,4x,4y; fraction order sx,tx,sy,ty
  localparam int unsigned FI [8] = '{3, 1, 3, 0, 2, 0, 2, 1};
  localparam logic [7:0]  NEGM  = 8'b0100_1011;

  logic           en;
  logic [LAT-1:0] v_q;

  assign en          = !v_q[LAT-1] || out_ready_i;
  assign pop_o       = en && in_valid_i;
  assign out_valid_o = v_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_valid_i};
    end
  end

  // ---- fractions: (num * 2^16 + |ext|/2) / |ext| ----
  logic [32:0]      fnum [4];
  logic [32:0]      fext [4];
  logic [31:0]      frem [4];
  logic [31:0]      flo  [4];
  logic [31:0]      fden [4];
  bqsf_pkg::fdtag_t ftag_in  [4];
  logic [31:0]      fquo     [4];
  logic [FTW-1:0]   ftag_raw [4];

  assign fnum[0] = item_i.nsx;  assign fext[0] = item_i.dx;
  assign fnum[1] = item_i.ntx;  assign fext[1] = item_i.dx;
  assign fnum[2] = item_i.nsy;  assign fext[2] = item_i.dy;
  assign fnum[3] = item_i.nty;  assign fext[3] = item_i.dy;

  always_comb begin
    logic [31:0] un, ud;
    logic [48:0] nn;
    logic        zero, sat;
    for (int k = 0; k < 4; k++) begin
      un   = bqsf_pkg::mag33(fnum[k]);
      ud   = bqsf_pkg::mag33(fext[k]);
      nn   = {1'b0, un, 16'b0} + {18'b0, ud[31:1]};
      zero = (ud == '0);
      sat  = !zero && ({15'b0, nn[48:32]} >= ud);
      frem[k] = (zero || sat) ? '0 : {15'b0, nn[48:32]};
      flo[k]  = nn[31:0];
      fden[k] = ud;
      ftag_in[k].zero = zero;
      ftag_in[k].sat  = sat;
      // zero-size cell gives plus one half whatever the numerator sign
      ftag_in[k].neg  = !zero && (fnum[k][32] ^ fext[k][32]);
      ftag_in[k].ext  = fext[k];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_fdiv
    bqsf_div #(.QW(FQW), .DW(32), .TW(FTW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (frem[k]),
      .lo_i  (flo[k]),
      .den_i (fden[k]),
      .tag_i (ftag_in[k]),
      .quo_o (fquo[k]),
      .tag_o (ftag_raw[k])
    );
  end

  bqsf_pkg::frac_t  frac_d   [4];
  bqsf_pkg::frac_t  frac_q   [4];
  bqsf_pkg::fdtag_t ftag_out [4];
  logic [32:0]      dx_q, dy_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ftag_out[k]   = bqsf_pkg::fdtag_t'(ftag_raw[k]);
      frac_d[k].mag = ftag_out[k].zero ? bqsf_pkg::FRAC_HALF :
                      (ftag_out[k].sat ? bqsf_pkg::FRAC_SAT : fquo[k]);
      frac_d[k].neg = ftag_out[k].neg && (frac_d[k].mag != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        frac_q[k] <= frac_d[k];
      end
      dx_q <= ftag_out[0].ext;
      dy_q <= ftag_out[2].ext;
    end
  end

  // ---- shape values ----
  function automatic logic [16:0] weight(bqsf_pkg::frac_t a, bqsf_pkg::frac_t b,
                                         logic [16:0] flr);
    logic [63:0] p, s;
    logic [47:0] m;
    logic [47:0] v;
    logic [16:0] w;
    p = {32'b0, a.mag} * {32'b0, b.mag};
    s = p + 64'd32768;
    m = s[63:16];
    v = ((a.neg ^ b.neg) && (m != '0)) ? '0 : m;
    w = (v > {31'b0, bqsf_pkg::W_ONE}) ? bqsf_pkg::W_ONE : v[16:0];
    if (w < flr) w = flr;
    if (w > bqsf_pkg::W_ONE) w = bqsf_pkg::W_ONE;
    return w;
  endfunction

  logic [16:0] wt [4];
  assign wt[0] = weight(frac_q[1], frac_q[3], shape_floor_i);
  assign wt[1] = weight(frac_q[0], frac_q[3], shape_floor_i);
  assign wt[2] = weight(frac_q[0], frac_q[2], shape_floor_i);
  assign wt[3] = weight(frac_q[1], frac_q[2], shape_floor_i);

  // ---- derivatives: (+-frac * 2^16 + |ext|/2) / |ext| ----
  logic [31:0]      grem [8];
  logic [30:0]      glo  [8];
  logic [31:0]      gden [8];
  bqsf_pkg::gdtag_t gtag_in  [8];
  logic [30:0]      gquo     [8];
  logic [GTW-1:0]   gtag_raw [8];

  always_comb begin
    bqsf_pkg::frac_t f;
    logic [32:0] e;
    logic [31:0] ud;
    logic [48:0] nn;
    logic        zero, sat, nneg;
    for (int k = 0; k < 8; k++) begin
      f    = frac_q[FI[k]];
      e    = (k % 2 == 0) ? dx_q : dy_q;
      ud   = bqsf_pkg::mag33(e);
      nn   = {1'b0, f.mag, 16'b0} + {18'b0, ud[31:1]};
      zero = (ud == '0);
      sat  = zero || ({14'b0, nn[48:31]} >= ud);
      nneg = NEGM[k] ? (!f.neg && (f.mag != '0)) : f.neg;
      grem[k] = sat ? '0 : {14'b0, nn[48:31]};
      glo[k]  = nn[30:0];
      gden[k] = ud;
      gtag_in[k].sat = sat;
      gtag_in[k].neg = zero ? nneg : (nneg ^ e[32]);
      gtag_in[k].wt  = (k < 4) ? wt[k % 4] : '0;
    end
  end

  for (genvar k = 0; k < 8; k++) begin : g_gdiv
    bqsf_div #(.QW(GQW), .DW(32), .TW(GTW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (grem[k]),
      .lo_i  (glo[k]),
      .den_i (gden[k]),
      .tag_i (gtag_in[k]),
      .quo_o (gquo[k]),
      .tag_o (gtag_raw[k])
    );
  end

  logic [31:0]      grad_d   [8];
  logic [31:0]      grad_q   [8];
  logic [16:0]      wt_q     [4];
  bqsf_pkg::gdtag_t gtag_out [8];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      gtag_out[k] = bqsf_pkg::gdtag_t'(gtag_raw[k]);
      if (gtag_out[k].sat) begin
        grad_d[k] = gtag_out[k].neg ? bqsf_pkg::GRAD_MIN : bqsf_pkg::GRAD_MAX;
      end else begin
        grad_d[k] = gtag_out[k].neg ? (32'd0 - {1'b0, gquo[k]}) : {1'b0, gquo[k]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        grad_q[k] <= grad_d[k];
      end
      for (int k = 0; k < 4; k++) begin
        wt_q[k] <= gtag_out[k].wt;
      end
    end
  end

  assign weight_1_o = wt_q[0];
  assign weight_2_o = wt_q[1];
  assign weight_3_o = wt_q[2];
  assign weight_4_o = wt_q[3];
  assign grad_1_x_o = grad_q[0];
  assign grad_1_y_o = grad_q[1];
  assign grad_2_x_o = grad_q[2];
  assign grad_2_y_o = grad_q[3];
  assign grad_3_x_o = grad_q[4];
  assign grad_3_y_o = grad_q[5];
  assign grad_4_x_o = grad_q[6];
  assign grad_4_y_o = grad_q[7];

  `BQ_ASSERT_NEXT(a_stall_hold, !en, v_q == $past(v_q))
  `BQ_ASSERT(a_weight_cap, !out_valid_o || (weight_1_o <= bqsf_pkg::W_ONE))

endmodule

[rtl/bilinear_quad_shape_function_top.sv]
// Bilinear Q4 shape values and derivatives for one particle per item. Takes one
// item every clock cycle while the queue has room; results leave in order, after
// passing through two chains of pipelined dividers that produce one quotient bit
// per stage (32 stages for the cell fractions, 31 for the derivatives). A two-entry
// queue separates the input subtractors from the divider pipeline, which stalls as
// a whole while a finished result waits at the output. shape_floor may be written
// at any time the block is idle and resets to 1.
module bilinear_quad_shape_function_top #(
  parameter int unsigned QUEUE_DEPTH = bqsf_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] cell_x_low_i,
  input  logic [31:0] cell_x_high_i,
  input  logic [31:0] cell_y_low_i,
  input  logic [31:0] cell_y_high_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] weight_1_o,
  output logic [16:0] weight_2_o,
  output logic [16:0] weight_3_o,
  output logic [16:0] weight_4_o,
  output logic [31:0] grad_1_x_o,
  output logic [31:0] grad_1_y_o,
  output logic [31:0] grad_2_x_o,
  output logic [31:0] grad_2_y_o,
  output logic [31:0] grad_3_x_o,
  output logic [31:0] grad_3_y_o,
  output logic [31:0] grad_4_x_o,
  output logic [31:0] grad_4_y_o
);

  logic [16:0]     shape_floor_q;
  logic            full, push, pop, q_valid;
  bqsf_pkg::diff_t push_item, head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_floor_q <= bqsf_pkg::FLOOR_RST;
    end else if (cfg_we_i) begin
      shape_floor_q <= cfg_wdata_i;
    end
  end

  bqsf_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cell_x_low_i  (cell_x_low_i),
    .cell_x_high_i (cell_x_high_i),
    .cell_y_low_i  (cell_y_low_i),
    .cell_y_high_i (cell_y_high_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .full_i        (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  bqsf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  bqsf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .shape_floor_i (shape_floor_q),
    .in_valid_i    (q_valid),
    .item_i        (head_item),
    .pop_o         (pop),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .weight_1_o    (weight_1_o),
    .weight_2_o    (weight_2_o),
    .weight_3_o    (weight_3_o),
    .weight_4_o    (weight_4_o),
    .grad_1_x_o    (grad_1_x_o),
    .grad_1_y_o    (grad_1_y_o),
    .grad_2_x_o    (grad_2_x_o),
    .grad_2_y_o    (grad_2_y_o),
    .grad_3_x_o    (grad_3_x_o),
    .grad_3_y_o    (grad_3_y_o),
    .grad_4_x_o    (grad_4_x_o),
    .grad_4_y_o    (grad_4_y_o)
  );

endmodule
